/* rtl/clp_pkg.sv */
// Shared types and constants for the cache lookup block with next-line prefetch.
// No dependencies; the set store, the top level and the testbench import this package.
`default_nettype none

package clp_pkg;

  // Configuration port geometry and register indexes.
  localparam int CFG_INDEX_W = 4;
  localparam int CFG_DATA_W  = 4;

  localparam logic [CFG_INDEX_W-1:0] REG_TWO_WAY_MODE   = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET_BITS    = 4'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_INDEX_BITS     = 4'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_PREFETCH_COUNT = 4'd3;

  // Register values after reset.
  localparam logic       RST_TWO_WAY_MODE   = 1'b1;
  localparam logic [2:0] RST_OFFSET_BITS    = 3'd4;
  localparam logic [3:0] RST_INDEX_BITS     = 4'd6;
  localparam logic [3:0] RST_PREFETCH_COUNT = 4'd0;

  // Operation codes of a demand access.
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_STORE = 1'b1;

  // Per-set bookkeeping kept next to the two tags.
  typedef struct packed {
    logic       ptr;
    logic [1:0] valid;
    logic [1:0] dirty;
  } line_state_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_LOOKUP
  } ctrl_state_t;

endpackage

`default_nettype wire

/* rtl/clp_ifs.sv */
// Valid/ready channel interfaces for the request and response sides of the block.
// Standalone; widths follow the address width parameter.
`default_nettype none

interface clp_req_if #(
  parameter int ADDRESS_WIDTH = 32
);
  logic                     valid;
  logic                     ready;
  logic [ADDRESS_WIDTH-1:0] address;
  logic                     operation;

  modport source (output valid, output address, output operation, input ready);
  modport sink   (input valid, input address, input operation, output ready);
endinterface

interface clp_rsp_if #(
  parameter int ADDRESS_WIDTH = 32
);
  logic                     valid;
  logic                     ready;
  logic [ADDRESS_WIDTH-1:0] access_address;
  logic                     is_prefetch;
  logic                     hit;
  logic                     dirty_eviction;
  logic                     last;

  modport source (output valid, output access_address, output is_prefetch, output hit,
                  output dirty_eviction, output last, input ready);
  modport sink   (input valid, input access_address, input is_prefetch, input hit,
                  input dirty_eviction, input last, output ready);
endinterface

`default_nettype wire

/* rtl/clp_set_store.sv */
// Set store: one row per set holding both tags and the valid, dirty and pointer bits.
// Depends on clp_pkg. The bookkeeping memory is swept to zero after reset.
`default_nettype none

module clp_set_store #(
  parameter int SET_BITS = 8,
  parameter int TAG_W    = 32
) (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         rd_en,
  input  wire  [SET_BITS-1:0]         rd_set,
  output logic [1:0][TAG_W-1:0]       rd_tags,
  output clp_pkg::line_state_t        rd_state,
  input  wire                         wr_en,
  input  wire  [SET_BITS-1:0]         wr_set,
  input  wire  [1:0][TAG_W-1:0]       wr_tags,
  input  wire  clp_pkg::line_state_t  wr_state,
  output logic                        clear_busy
);
  import clp_pkg::*;

  localparam int NUM_SETS = 1 << SET_BITS;

  logic [1:0][TAG_W-1:0] tag_mem   [NUM_SETS];
  line_state_t           state_mem [NUM_SETS];

  logic [SET_BITS-1:0] clr_idx;

  // Sweep counter: one row per cycle until every set is cleared.
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_busy <= 1'b1;
      clr_idx    <= '0;
    end else if (clear_busy) begin
      if (clr_idx == {SET_BITS{1'b1}}) begin
        clear_busy <= 1'b0;
      end
      clr_idx <= clr_idx + 1'b1;
    end
  end

  // Tags carry no reset; they are only trusted behind a valid bit.
  always_ff @(posedge clk) begin
    if (wr_en && !clear_busy) begin
      tag_mem[wr_set] <= wr_tags;
    end
    if (rd_en) begin
      rd_tags <= tag_mem[rd_set];
    end
  end

  always_ff @(posedge clk) begin
    if (clear_busy) begin
      state_mem[clr_idx] <= '0;
    end else if (wr_en) begin
      state_mem[wr_set] <= wr_state;
    end
    if (rd_en) begin
      rd_state <= state_mem[rd_set];
    end
  end

endmodule

`default_nettype wire

/* rtl/cache_lookup_with_next_line_prefetch_core.sv */
// Top level of the cache lookup block with next-line prefetch.
// Depends on clp_pkg, clp_ifs (clp_req_if, clp_rsp_if) and clp_set_store.
//
// Usage:
// The req channel carries one demand access per word: a byte address and an
// operation (load or store). The rsp channel returns one word per lookup: the
// address looked up, whether it was a prefetch, hit, dirty eviction, and a
// last flag on the final word caused by the request. A hit gives one word; a
// miss gives one demand word followed by prefetch_count prefetch words at
// successive block addresses.
// Each lookup has two steps: it reads the set row from the set store, then
// compares tags, writes the updated row back and loads the response
// register. A miss with N prefetches repeats both steps for each prefetch,
// and the compare step waits while the response side stalls. The read of
// the next lookup is issued only after the previous write-back, so no two
// accesses to a set ever overlap.
// After reset the valid, dirty and pointer bits are swept to zero, one set
// per cycle over all 2**MAX_INDEX_BITS sets; req.ready stays low meanwhile,
// while configuration writes are taken as usual.
// The response register decouples the two sides: a new request is accepted
// while the last word of the previous one still waits. When the receiver
// stalls with the register full, the block holds its pending lookup.
// Configuration writes land at once and must only be issued while idle.
`default_nettype none

module cache_lookup_with_next_line_prefetch_core #(
  parameter int MAX_INDEX_BITS = 8,
  parameter int MAX_PREFETCH   = 15,
  parameter int ADDRESS_WIDTH  = 32
) (
  input  wire                                clk,
  input  wire                                rst,
  input  wire                                cfg_we,
  input  wire  [clp_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire  [clp_pkg::CFG_DATA_W-1:0]     cfg_data,
  clp_req_if.sink                            req,
  clp_rsp_if.source                          rsp
);
  import clp_pkg::*;

  localparam int SW     = MAX_INDEX_BITS;
  localparam int AW     = ADDRESS_WIDTH;
  localparam int PF_W   = $clog2(MAX_PREFETCH + 1);
  localparam int CNT_W  = (PF_W > 4) ? PF_W : 4;

  // Configuration registers.
  logic       two_way_mode;
  logic [2:0] offset_bits;
  logic [3:0] index_bits;
  logic [3:0] prefetch_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      two_way_mode   <= RST_TWO_WAY_MODE;
      offset_bits    <= RST_OFFSET_BITS;
      index_bits     <= RST_INDEX_BITS;
      prefetch_count <= RST_PREFETCH_COUNT;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TWO_WAY_MODE:   two_way_mode   <= cfg_data[0];
        REG_OFFSET_BITS:    offset_bits    <= cfg_data[2:0];
        REG_INDEX_BITS:     index_bits     <= cfg_data[3:0];
        REG_PREFETCH_COUNT: prefetch_count <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Control state and per-item working registers.
  ctrl_state_t state, state_next;
  logic [AW-1:0]    cur_addr;
  logic             is_pf;
  logic             op_store;
  logic [CNT_W-1:0] pf_left;

  // Response register.
  logic          out_valid;
  logic [AW-1:0] out_addr;
  logic          out_pf;
  logic          out_hit;
  logic          out_ev;
  logic          out_last;

  // Set store connections.
  logic                rd_en;
  logic                wr_en;
  logic [SW-1:0]       lk_set;
  logic [1:0][AW-1:0]  rd_tags;
  line_state_t         rd_state;
  logic [1:0][AW-1:0]  wr_tags;
  line_state_t         wr_state;
  logic                clear_busy;

  logic accept;
  logic out_free;
  logic out_load;
  logic more;

  assign accept   = req.valid && req.ready;
  assign out_free = !out_valid || rsp.ready;

  // Address split. The index width saturates at the number of set bits the
  // store provides; the tag is everything above offset and index.
  logic [3:0]    ib_sat;
  logic [SW-1:0] set_mask;
  logic [AW-1:0] lk_addr;
  logic [AW-1:0] lk_shifted;
  logic [4:0]    tag_shift;
  logic [AW-1:0] tag;
  logic [AW-1:0] step;
  logic [CNT_W-1:0] pf_sat;

  always_comb begin
    ib_sat     = (index_bits > 4'(MAX_INDEX_BITS)) ? 4'(MAX_INDEX_BITS) : index_bits;
    set_mask   = ~({SW{1'b1}} << ib_sat);
    lk_addr    = (state == ST_IDLE) ? req.address : cur_addr;
    lk_shifted = lk_addr >> offset_bits;
    lk_set     = lk_shifted[SW-1:0] & set_mask;
    tag_shift  = {2'b00, offset_bits} + {1'b0, ib_sat};
    tag        = cur_addr >> tag_shift;
    step       = AW'(1) << offset_bits;
    pf_sat     = (CNT_W'(prefetch_count) > CNT_W'(MAX_PREFETCH)) ?
                 CNT_W'(MAX_PREFETCH) : CNT_W'(prefetch_count);
  end

  // Tag compare and row update for the lookup in flight. Way 0 wins when
  // both ways match. A miss always fills the way named by the pointer in
  // two-way mode, even if the other way is empty.
  logic store_now;
  logic m0;
  logic m1;
  logic hit;
  logic victim;
  logic ev;

  always_comb begin
    store_now = op_store && !is_pf;
    m0        = rd_state.valid[0] && (rd_tags[0] == tag);
    m1        = two_way_mode && rd_state.valid[1] && (rd_tags[1] == tag);
    hit       = m0 || m1;
    victim    = two_way_mode ? rd_state.ptr : 1'b0;
    ev        = 1'b0;
    wr_tags   = rd_tags;
    wr_state  = rd_state;
    if (hit) begin
      if (store_now) begin
        wr_state.dirty[m0 ? 1'b0 : 1'b1] = 1'b1;
      end
    end else begin
      ev                      = rd_state.valid[victim] && rd_state.dirty[victim];
      wr_tags[victim]         = tag;
      wr_state.valid[victim]  = 1'b1;
      wr_state.dirty[victim]  = store_now;
      if (two_way_mode && !is_pf) begin
        wr_state.ptr = ~rd_state.ptr;
      end
    end
    // Prefetches follow only a demand miss, and stop when the count runs out.
    more = !(hit && !is_pf) && (pf_left != '0);
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR:  if (!clear_busy) state_next = ST_IDLE;
      ST_IDLE:   if (accept) state_next = ST_LOOKUP;
      ST_READ:   state_next = ST_LOOKUP;
      ST_LOOKUP: begin
        if (out_free) begin
          state_next = more ? ST_READ : ST_IDLE;
        end
      end
      default:   state_next = ST_CLEAR;
    endcase
  end

  // Control outputs of the sequencer.
  always_comb begin
    req.ready = 1'b0;
    rd_en     = 1'b0;
    wr_en     = 1'b0;
    out_load  = 1'b0;
    case (state)
      ST_CLEAR:  ;
      ST_IDLE: begin
        req.ready = 1'b1;
        rd_en     = req.valid;
      end
      ST_READ:   rd_en = 1'b1;
      ST_LOOKUP: begin
        wr_en    = out_free;
        out_load = out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Working registers for the current request.
  always_ff @(posedge clk) begin
    if (accept) begin
      cur_addr <= req.address;
      is_pf    <= 1'b0;
      op_store <= (req.operation == OP_STORE);
      pf_left  <= pf_sat;
    end else if (out_load && more) begin
      cur_addr <= cur_addr + step;
      is_pf    <= 1'b1;
      pf_left  <= pf_left - 1'b1;
    end
  end

  // Response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_addr <= cur_addr;
      out_pf   <= is_pf;
      out_hit  <= hit;
      out_ev   <= ev;
      out_last <= !more;
    end
  end

  assign rsp.valid          = out_valid;
  assign rsp.access_address = out_addr;
  assign rsp.is_prefetch    = out_pf;
  assign rsp.hit            = out_hit;
  assign rsp.dirty_eviction = out_ev;
  assign rsp.last           = out_last;

  clp_set_store #(
    .SET_BITS (SW),
    .TAG_W    (AW)
  ) u_set_store (
    .clk        (clk),
    .rst        (rst),
    .rd_en      (rd_en),
    .rd_set     (lk_set),
    .rd_tags    (rd_tags),
    .rd_state   (rd_state),
    .wr_en      (wr_en),
    .wr_set     (lk_set),
    .wr_tags    (wr_tags),
    .wr_state   (wr_state),
    .clear_busy (clear_busy)
  );

  // No request is taken while the set store is still being cleared.
  assert property (@(posedge clk) disable iff (rst) clear_busy |-> !req.ready)
    else $error("request accepted during clearing sweep");

  // Every compare cycle is preceded by a read of the set row.
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_LOOKUP && $past(state) != ST_LOOKUP) |-> $past(rd_en))
    else $error("lookup without a preceding set read");

  // A read and a write-back never share a cycle, so a set is never read stale.
  assert property (@(posedge clk) disable iff (rst) !(rd_en && wr_en))
    else $error("set read overlaps write-back");

  // A result never overwrites a word the receiver has not taken.
  assert property (@(posedge clk) disable iff (rst) out_load |-> (!out_valid || rsp.ready))
    else $error("response register overwritten");

  // A write-back always comes with a response word.
  assert property (@(posedge clk) disable iff (rst) wr_en |=> out_valid)
    else $error("write-back without a response word");

endmodule

`default_nettype wire

/* tb/sv/cache_lookup_with_next_line_prefetch_core_tb.sv */
// Self-checking testbench for cache_lookup_with_next_line_prefetch_core.
// Needs clp_pkg, clp_ifs (clp_req_if, clp_rsp_if) and the RTL of the block.
// A local cache predictor builds the expected lookup words and checks every response word.
module cache_lookup_with_next_line_prefetch_core_tb;
  import clp_pkg::*;

  localparam int NUM_SETS      = 256;
  localparam int NUM_LINES     = 2 * NUM_SETS;
  localparam int SET_BITS_MAX  = 8;
  localparam int CYCLE_LIMIT   = 400000;
  // Pause after the last expected word before touching the registers.
  localparam int SETTLE_CYCLES = 8;
  localparam int REPORT_LIMIT  = 10;
  // Length of a requested receiver hold-off, in cycles.
  localparam int RECEIVER_HOLD_CYCLES = 400;

  // One response word as the block presents it.
  typedef struct packed {
    logic [31:0] access_address;
    logic        is_prefetch;
    logic        hit;
    logic        dirty_eviction;
    logic        last;
  } lookup_word_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  clp_req_if #(.ADDRESS_WIDTH(32)) req_bus ();
  clp_rsp_if #(.ADDRESS_WIDTH(32)) rsp_bus ();

  cache_lookup_with_next_line_prefetch_core dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_bus),
    .rsp       (rsp_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Predictor state: its own copy of the tag array, line flags, per-set
  // victim pointers and the four configuration registers.
  logic [31:0] tag_mem [NUM_LINES];
  bit          line_ok [NUM_LINES];
  bit          line_mod [NUM_LINES];
  bit          victim_way [NUM_SETS];
  logic        cfg_two_way;
  logic [2:0]  cfg_offset;
  logic [3:0]  cfg_index_bits;
  logic [3:0]  cfg_prefetch;

  // Words the block still owes us, oldest first.
  lookup_word_t expected_words[$];

  int          mismatch_count = 0;
  int          cycle_count = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned receiver_idle_pct = 0;
  // Bumped by a test to ask the response side for one long hold-off; the
  // response process owns the countdown itself.
  int          hold_requests = 0;
  int          hold_served = 0;
  int          hold_left = 0;
  // A handful of tags per random phase so that hits, conflicts and dirty
  // evictions actually happen instead of a stream of cold misses.
  logic [31:0] tag_pool [4];

  // One tag lookup against the predictor state. A hit only marks the line
  // dirty on a store; a miss fills the victim way and reports whether a valid
  // dirty line was thrown out. In two-way mode the victim is the way the set
  // pointer names, even if the other way is empty, and only demand fills flip
  // the pointer. Way 0 is searched first, so it wins when both ways match.
  function automatic void cache_probe(input logic [31:0] addr, input bit is_pf,
                                      input bit is_store, output bit hit,
                                      output bit dirty_out);
    int unsigned ob;
    int unsigned ib;
    int unsigned set_no;
    int unsigned base;
    int unsigned ways;
    int unsigned victim;
    logic [31:0] tag;
    ob = cfg_offset;
    // Index widths beyond the array saturate.
    ib = (cfg_index_bits > SET_BITS_MAX) ? SET_BITS_MAX : cfg_index_bits;
    set_no = (addr >> ob) & ((32'd1 << ib) - 32'd1);
    tag = addr >> (ob + ib);
    base = set_no * 2;
    ways = cfg_two_way ? 2 : 1;
    hit = 1'b0;
    dirty_out = 1'b0;
    for (int way = 0; way < ways; way++) begin
      if (line_ok[base + way] && tag_mem[base + way] == tag) begin
        if (is_store) line_mod[base + way] = 1'b1;
        hit = 1'b1;
        return;
      end
    end
    victim = cfg_two_way ? victim_way[set_no] : 0;
    dirty_out = line_ok[base + victim] && line_mod[base + victim];
    tag_mem[base + victim] = tag;
    line_ok[base + victim] = 1'b1;
    line_mod[base + victim] = is_store;
    if (cfg_two_way && !is_pf) victim_way[set_no] = !victim;
  endfunction

  // Expected words for one demand access: the demand lookup, then on a miss
  // the next-line prefetches, each one block further up with 32-bit
  // wraparound. Prefetches behave as loads and never chain.
  function automatic void predict_lookups(input logic [31:0] addr, input logic op);
    lookup_word_t words[$];
    logic [31:0]  cur;
    bit           hit;
    bit           evicted;
    bit           demand_hit;
    cur = addr;
    cache_probe(cur, 1'b0, op == OP_STORE, hit, evicted);
    demand_hit = hit;
    words.push_back('{access_address: cur, is_prefetch: 1'b0, hit: hit,
                      dirty_eviction: evicted, last: 1'b0});
    if (!demand_hit) begin
      for (int n = 0; n < cfg_prefetch; n++) begin
        cur = cur + (32'd1 << cfg_offset);
        cache_probe(cur, 1'b1, 1'b0, hit, evicted);
        words.push_back('{access_address: cur, is_prefetch: 1'b1, hit: hit,
                          dirty_eviction: evicted, last: 1'b0});
      end
    end
    words[words.size() - 1].last = 1'b1;
    foreach (words[i]) expected_words.push_back(words[i]);
  endfunction

  // Random address under the current split: mostly a pool tag in one of the
  // four lowest sets with a random offset, sometimes a fully random address.
  function automatic logic [31:0] pick_address();
    int unsigned ob;
    int unsigned ib;
    logic [31:0] addr;
    ob = cfg_offset;
    ib = (cfg_index_bits > SET_BITS_MAX) ? SET_BITS_MAX : cfg_index_bits;
    if ($urandom_range(0, 99) < 20) return $urandom();
    addr = tag_pool[$urandom_range(0, 3)] << (ob + ib);
    addr = addr | (($urandom_range(0, 3) & ((32'd1 << ib) - 32'd1)) << ob);
    addr = addr | ($urandom() & ((32'd1 << ob) - 32'd1));
    return addr;
  endfunction

  function automatic logic pick_operation();
    return ($urandom_range(0, 99) < 40) ? OP_STORE : OP_LOAD;
  endfunction

  // Offers one demand word, with random idle cycles in front, and waits until
  // the block takes it. The predictor runs at the accepting edge, so it
  // always sees the configuration the block uses for this access.
  task automatic send_access(input logic [31:0] addr, input logic op);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(negedge clk);
    end
    req_bus.valid     <= 1'b1;
    req_bus.address   <= addr;
    req_bus.operation <= op;
    do @(posedge clk); while (!req_bus.ready);
    predict_lookups(addr, op);
  endtask

  // Drops the request valid, lets every owed word come back and then gives
  // the block a few more cycles to settle before the registers change.
  task automatic wait_drained();
    @(negedge clk);
    req_bus.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Leaves the write enable high; the caller lowers it after its last write,
  // so back-to-back writes never toggle the enable within one time step.
  task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_TWO_WAY_MODE:   cfg_two_way = data[0];
      REG_OFFSET_BITS:    cfg_offset = data[2:0];
      REG_INDEX_BITS:     cfg_index_bits = data;
      REG_PREFETCH_COUNT: cfg_prefetch = data;
      default: ;
    endcase
  endtask

  task automatic set_config(input logic [3:0] two, input logic [3:0] ob,
                            input logic [3:0] ib, input logic [3:0] pc);
    wait_drained();
    write_register(REG_TWO_WAY_MODE, two);
    write_register(REG_OFFSET_BITS, ob);
    write_register(REG_INDEX_BITS, ib);
    write_register(REG_PREFETCH_COUNT, pc);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic flag_mismatch(input string why, input lookup_word_t want,
                               input lookup_word_t got);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("mismatch (%s): expected addr=%h pf=%0b hit=%0b ev=%0b last=%0b",
               why, want.access_address, want.is_prefetch, want.hit,
               want.dirty_eviction, want.last);
      $display("              got      addr=%h pf=%0b hit=%0b ev=%0b last=%0b",
               got.access_address, got.is_prefetch, got.hit,
               got.dirty_eviction, got.last);
    end
  endtask

  // Response checker: every accepted word is matched against the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    lookup_word_t got;
    lookup_word_t want;
    if (!rst && rsp_bus.valid && rsp_bus.ready) begin
      got = '{access_address: rsp_bus.access_address, is_prefetch: rsp_bus.is_prefetch,
              hit: rsp_bus.hit, dirty_eviction: rsp_bus.dirty_eviction,
              last: rsp_bus.last};
      if (expected_words.size() == 0) begin
        flag_mismatch("word with no lookup pending", '0, got);
      end else begin
        want = expected_words.pop_front();
        if (got.access_address !== want.access_address ||
            got.is_prefetch !== want.is_prefetch ||
            got.hit !== want.hit ||
            got.dirty_eviction !== want.dirty_eviction ||
            got.last !== want.last) begin
          flag_mismatch("field differs", want, got);
        end
      end
    end
  end

  // Response-side flow control: a requested hold-off counts down first,
  // otherwise ready drops at random with the current idle percentage.
  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = RECEIVER_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      rsp_bus.ready <= 1'b0;
    end else begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Reset configuration: two-way, 16-byte blocks, 64 sets, no prefetch.
  // Set 0 gets a load miss, a store hit that dirties way 0, a miss into the
  // still empty way 1, and a third tag that throws out the dirty way 0.
  task automatic test_reset_defaults();
    send_access(32'h0000_0000, OP_LOAD);
    send_access(32'h0000_0000, OP_STORE);
    send_access(32'hFFFF_FFFF, OP_LOAD);
    send_access(32'h0000_0400, OP_STORE);
    send_access(32'h0000_0800, OP_LOAD);
  endtask

  // Builds a set whose two ways hold the same tag by switching between
  // direct-mapped and two-way mode; a store must then land on way 0, which
  // the next conflict miss evicts as dirty.
  task automatic test_way_aliasing();
    set_config(4'd1, 4'd4, 4'd6, 4'd0);
    send_access(32'h0000_1230, OP_LOAD);
    set_config(4'd0, 4'd4, 4'd6, 4'd0);
    send_access(32'h0000_1630, OP_LOAD);
    set_config(4'd1, 4'd4, 4'd6, 4'd0);
    send_access(32'h0000_1230, OP_LOAD);
    set_config(4'd0, 4'd4, 4'd6, 4'd0);
    send_access(32'h0000_1230, OP_LOAD);
    set_config(4'd1, 4'd4, 4'd6, 4'd0);
    send_access(32'h0000_1230, OP_STORE);
    send_access(32'h0000_1A30, OP_LOAD);
  endtask

  // Largest blocks, all sets and the longest prefetch run, starting near the
  // top of the address space so the prefetch addresses wrap through zero.
  task automatic test_prefetch_wrap();
    set_config(4'd1, 4'd7, 4'd8, 4'd15);
    send_access(32'hFFFF_FF80, OP_LOAD);
    send_access(32'h0000_0000, OP_LOAD);
    send_access(32'hFFFF_FFFF, OP_STORE);
  endtask

  // Writes to indexes past the register list must be ignored. Unused high
  // data bits are dropped, and an index width of 15 saturates to 8; with
  // single-byte blocks the whole upper address becomes the tag.
  task automatic test_narrow_split();
    wait_drained();
    write_register(CFG_INDEX_W'(4), 4'hF);
    write_register(CFG_INDEX_W'(15), 4'h1);
    set_config(4'hE, 4'h8, 4'hF, 4'h3);
    send_access(32'h5A5A_5A5A, OP_STORE);
    send_access(32'h5A5A_5A5B, OP_LOAD);
    send_access(32'hA5A5_A5A5, OP_LOAD);
    send_access(32'hFFFF_FFFF, OP_STORE);
  endtask

  task automatic run_random_phase(input int n_items, input logic [3:0] two,
                                  input logic [3:0] ob, input logic [3:0] ib,
                                  input logic [3:0] pc);
    set_config(two, ob, ib, pc);
    foreach (tag_pool[i]) tag_pool[i] = $urandom();
    repeat (n_items) send_access(pick_address(), pick_operation());
  endtask

  // Random traffic under a spread of settings, first with the sender lightly
  // and the receiver heavily idling, then the reverse, then at full rate.
  task automatic test_random_traffic();
    sender_idle_pct   = 20;
    receiver_idle_pct = 61;
    run_random_phase(48, 4'd1, 4'd4, 4'd6, 4'd2);
    run_random_phase(48, 4'd0, 4'd0, 4'd0, 4'd0);
    run_random_phase(48, 4'd1, 4'd7, 4'd15, 4'd15);
    sender_idle_pct   = 61;
    receiver_idle_pct = 20;
    run_random_phase(48, 4'd1, 4'd2, 4'd3, 4'd1);
    run_random_phase(48, 4'd0, 4'd5, 4'd8, 4'd4);
    run_random_phase(48, 4'($urandom_range(0, 1)), 4'($urandom_range(0, 7)),
                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 4)));
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    run_random_phase(48, 4'($urandom_range(0, 1)), 4'($urandom_range(0, 7)),
                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 4)));
    run_random_phase(48, 4'($urandom_range(0, 1)), 4'($urandom_range(0, 7)),
                     4'($urandom_range(0, 15)), 4'($urandom_range(0, 4)));
    run_random_phase(48, 4'd1, 4'd0, 4'd2, 4'd3);
  endtask

  // The receiver refuses words for a long stretch while the sender keeps
  // offering accesses back to back; the block has to fill up, drop its
  // request ready and resume cleanly once words flow again.
  task automatic test_output_backpressure();
    sender_idle_pct   = 0;
    receiver_idle_pct = 0;
    set_config(4'd1, 4'd4, 4'd6, 4'd3);
    foreach (tag_pool[i]) tag_pool[i] = $urandom();
    hold_requests++;
    repeat (24) send_access(pick_address(), pick_operation());
  endtask

  initial begin
    // Predictor starts from the reset state of the block.
    foreach (line_ok[i]) begin
      tag_mem[i]  = '0;
      line_ok[i]  = 1'b0;
      line_mod[i] = 1'b0;
    end
    foreach (victim_way[i]) victim_way[i] = 1'b0;
    cfg_two_way    = RST_TWO_WAY_MODE;
    cfg_offset     = RST_OFFSET_BITS;
    cfg_index_bits = RST_INDEX_BITS;
    cfg_prefetch   = RST_PREFETCH_COUNT;

    rst               = 1'b1;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    req_bus.valid     = 1'b0;
    req_bus.address   = '0;
    req_bus.operation = OP_LOAD;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // The block sweeps its line flags after reset with request ready low;
    // the first send simply waits for it.
    sender_idle_pct   = 20;
    receiver_idle_pct = 61;
    test_reset_defaults();
    test_way_aliasing();
    test_prefetch_wrap();
    test_narrow_split();
    test_random_traffic();
    test_output_backpressure();

    // Wait out the last words, then leave room for anything unexpected.
    wait_drained();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/clp_pkg.sv
rtl/clp_ifs.sv
rtl/clp_set_store.sv
rtl/cache_lookup_with_next_line_prefetch_core.sv
tb/sv/cache_lookup_with_next_line_prefetch_core_tb.sv
